FILE: rtl/jad_pkg.sv
// Shared types, constants and register map of the joystick axis direction block.
`default_nettype none

package jad_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned PCT_W    = 16;
  localparam int unsigned NUM_W    = 15;
  localparam int unsigned DIV_W    = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [NUM_W-1:0] PCT_SCALE = NUM_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAX        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_SAMPLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES   = 3'd4;

  localparam logic [SAMPLE_W-1:0] DEADZONE_RST        = 8'd30;
  localparam logic [SAMPLE_W-1:0] AXIS_MIN_RST        = 8'd115;
  localparam logic [SAMPLE_W-1:0] AXIS_MAX_RST        = 8'd255;
  localparam logic [COUNT_W-1:0]  MEASURE_SAMPLES_RST = 4'd2;
  localparam logic [COUNT_W-1:0]  CALIB_SAMPLES_RST   = 4'd4;

  localparam logic MODE_CALIB   = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  typedef enum logic [2:0] {
    DIR_NEUTRAL = 3'd0,
    DIR_UP      = 3'd1,
    DIR_DOWN    = 3'd2,
    DIR_LEFT    = 3'd3,
    DIR_RIGHT   = 3'd4
  } dir_e;

  typedef enum logic [1:0] {
    OP_AVG_X,
    OP_AVG_Y,
    OP_PCT_X,
    OP_PCT_Y
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic capture;
    logic emit;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic in_mode;
    logic zero_target;
    logic close;
    logic mode;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/jad_ifs.sv
// Handshake channel interfaces for samples, results and register writes.
`default_nettype none

interface jad_sample_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] sample_x;
  logic [7:0] sample_y;

  modport source (output valid, mode, sample_x, sample_y, input ready);
  modport sink   (input valid, mode, sample_x, sample_y, output ready);
endinterface

interface jad_result_if;
  logic               valid;
  logic               ready;
  logic               was_calibration;
  logic [7:0]         avg_x;
  logic [7:0]         avg_y;
  logic signed [15:0] percent_x;
  logic signed [15:0] percent_y;
  logic [2:0]         direction;

  modport source (output valid, was_calibration, avg_x, avg_y, percent_x, percent_y,
                  direction, input ready);
  modport sink   (input valid, was_calibration, avg_x, avg_y, percent_x, percent_y,
                  direction, output ready);
endinterface

interface jad_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/jad_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module jad_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [jad_pkg::DIV_W-1:0]    dividend_i,
  input  logic [jad_pkg::DIV_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [jad_pkg::DIV_W-1:0]    quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [jad_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [jad_pkg::DIV_W-1:0]        rem_q, rem_d;
  logic [jad_pkg::DIV_W-1:0]        quo_q, quo_d;
  logic [jad_pkg::DIV_W-1:0]        div_q, div_d;
  logic [jad_pkg::DIV_W:0]          rem_shift;
  logic [jad_pkg::DIV_W:0]          diff;
  logic                             fits;

  assign rem_shift = {rem_q, quo_q[jad_pkg::DIV_W-1]};
  assign fits      = rem_shift >= {1'b0, div_q};
  assign diff      = rem_shift - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[jad_pkg::DIV_W-1:0] : rem_shift[jad_pkg::DIV_W-1:0];
      quo_d = {quo_q[jad_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == jad_pkg::DIV_CNT_W'(jad_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/jad_datapath.sv
// Datapath: registers, sample accumulation, scaling operands, direction and output register.
`default_nettype none

module jad_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  jad_pkg::cmd_t                     cmd_i,
  output jad_pkg::sts_t                     sts_o,
  input  logic                              in_mode_i,
  input  logic [jad_pkg::SAMPLE_W-1:0]      in_x_i,
  input  logic [jad_pkg::SAMPLE_W-1:0]      in_y_i,
  input  logic                              cfg_we_i,
  input  logic [jad_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [jad_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_cal_o,
  output logic [jad_pkg::SAMPLE_W-1:0]      out_avg_x_o,
  output logic [jad_pkg::SAMPLE_W-1:0]      out_avg_y_o,
  output logic signed [jad_pkg::PCT_W-1:0]  out_pct_x_o,
  output logic signed [jad_pkg::PCT_W-1:0]  out_pct_y_o,
  output logic [2:0]                        out_dir_o
);

  logic [jad_pkg::SAMPLE_W-1:0] deadzone_q, axis_min_q, axis_max_q;
  logic [jad_pkg::COUNT_W-1:0]  meas_cnt_q, cal_cnt_q;

  logic [jad_pkg::SUM_W-1:0]    sum_x_q, sum_y_q;
  logic [jad_pkg::COUNT_W-1:0]  count_q;
  logic                         group_mode_q;
  logic [jad_pkg::SAMPLE_W-1:0] zero_x_q, zero_y_q;

  logic                         mode_q;
  logic [jad_pkg::SUM_W-1:0]    lat_x_q, lat_y_q;
  logic [jad_pkg::COUNT_W-1:0]  lat_cnt_q;
  logic [jad_pkg::SAMPLE_W-1:0] avg_x_q, avg_y_q;
  logic signed [jad_pkg::PCT_W-1:0] pct_x_q, pct_y_q;

  logic                         out_valid_q;
  logic                         out_cal_q;
  logic [jad_pkg::SAMPLE_W-1:0] out_avg_x_q, out_avg_y_q;
  logic signed [jad_pkg::PCT_W-1:0] out_pct_x_q, out_pct_y_q;
  jad_pkg::dir_e                out_dir_q;

  logic [jad_pkg::COUNT_W-1:0]  target;
  logic                         zero_target;
  logic                         restart;
  logic [jad_pkg::SUM_W-1:0]    nsum_x, nsum_y;
  logic [jad_pkg::COUNT_W-1:0]  ncnt;
  logic                         close;

  logic [jad_pkg::SAMPLE_W-1:0] sc_val, sc_zero, mag;
  logic                         ge;
  logic [jad_pkg::NUM_W-1:0]    num;
  logic [jad_pkg::DIV_W-1:0]    den;
  logic [jad_pkg::DIV_W-1:0]    dividend, divisor;
  logic                         div_done;
  logic [jad_pkg::DIV_W-1:0]    quotient;
  logic signed [jad_pkg::PCT_W-1:0] pct_res;

  logic signed [jad_pkg::PCT_W:0] cx, cy, ay, dz;
  jad_pkg::dir_e                dir;

  // Accumulation of the incoming sample
  assign target      = in_mode_i ? meas_cnt_q : cal_cnt_q;
  assign zero_target = target == '0;
  assign restart     = (count_q != '0) && (group_mode_q != in_mode_i);
  assign nsum_x      = (restart ? '0 : sum_x_q) + jad_pkg::SUM_W'(in_x_i);
  assign nsum_y      = (restart ? '0 : sum_y_q) + jad_pkg::SUM_W'(in_y_i);
  assign ncnt        = (restart ? '0 : count_q) + 1'b1;
  assign close       = !zero_target && !(ncnt < target);

  // Scaling operands for the axis in work
  assign sc_val  = (cmd_i.op == jad_pkg::OP_PCT_Y) ? avg_y_q : avg_x_q;
  assign sc_zero = (cmd_i.op == jad_pkg::OP_PCT_Y) ? zero_y_q : zero_x_q;
  assign ge      = sc_val >= sc_zero;
  assign mag     = ge ? (sc_val - sc_zero) : (sc_zero - sc_val);
  assign num     = jad_pkg::NUM_W'(mag) * jad_pkg::PCT_SCALE;
  assign den     = ge ? (jad_pkg::DIV_W'(axis_max_q) - jad_pkg::DIV_W'(sc_zero))
                      : (jad_pkg::DIV_W'(sc_zero) - jad_pkg::DIV_W'(axis_min_q));

  always_comb begin
    unique case (cmd_i.op)
      jad_pkg::OP_AVG_X: begin
        dividend = jad_pkg::DIV_W'(lat_x_q);
        divisor  = jad_pkg::DIV_W'(lat_cnt_q);
      end
      jad_pkg::OP_AVG_Y: begin
        dividend = jad_pkg::DIV_W'(lat_y_q);
        divisor  = jad_pkg::DIV_W'(lat_cnt_q);
      end
      default: begin
        dividend = jad_pkg::DIV_W'(num);
        divisor  = den;
      end
    endcase
  end

  always_comb begin
    if (den == '0) begin
      pct_res = '0;
    end else if (ge) begin
      pct_res = quotient;
    end else begin
      pct_res = -quotient;
    end
  end

  jad_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Direction with deadzone, X wins ties
  assign cx = {pct_x_q[jad_pkg::PCT_W-1], pct_x_q};
  assign cy = {pct_y_q[jad_pkg::PCT_W-1], pct_y_q};
  assign ay = (cy < 0) ? -cy : cy;
  assign dz = $signed({{(jad_pkg::PCT_W + 1 - jad_pkg::SAMPLE_W){1'b0}}, deadzone_q});

  always_comb begin
    priority if (cx > dz && cx >= ay) begin
      dir = jad_pkg::DIR_RIGHT;
    end else if (cx < -dz && -cx >= ay) begin
      dir = jad_pkg::DIR_LEFT;
    end else if (cy > dz) begin
      dir = jad_pkg::DIR_UP;
    end else if (cy < -dz) begin
      dir = jad_pkg::DIR_DOWN;
    end else begin
      dir = jad_pkg::DIR_NEUTRAL;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= jad_pkg::DEADZONE_RST;
      axis_min_q <= jad_pkg::AXIS_MIN_RST;
      axis_max_q <= jad_pkg::AXIS_MAX_RST;
      meas_cnt_q <= jad_pkg::MEASURE_SAMPLES_RST;
      cal_cnt_q  <= jad_pkg::CALIB_SAMPLES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jad_pkg::CFG_DEADZONE:        deadzone_q <= cfg_data_i;
        jad_pkg::CFG_AXIS_MIN:        axis_min_q <= cfg_data_i;
        jad_pkg::CFG_AXIS_MAX:        axis_max_q <= cfg_data_i;
        jad_pkg::CFG_MEASURE_SAMPLES: meas_cnt_q <= cfg_data_i[jad_pkg::COUNT_W-1:0];
        jad_pkg::CFG_CALIB_SAMPLES:   cal_cnt_q  <= cfg_data_i[jad_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Group accumulation and zero points
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      count_q      <= '0;
      group_mode_q <= jad_pkg::MODE_CALIB;
      zero_x_q     <= '0;
      zero_y_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        group_mode_q <= in_mode_i;
        if (zero_target || close) begin
          sum_x_q <= '0;
          sum_y_q <= '0;
          count_q <= '0;
        end else begin
          sum_x_q <= nsum_x;
          sum_y_q <= nsum_y;
          count_q <= ncnt;
        end
      end
      if (cmd_i.emit && mode_q == jad_pkg::MODE_CALIB) begin
        zero_x_q <= avg_x_q;
        zero_y_q <= avg_y_q;
      end
    end
  end

  // Working registers of the closed group
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q    <= in_mode_i;
      lat_x_q   <= nsum_x;
      lat_y_q   <= nsum_y;
      lat_cnt_q <= ncnt;
      if (zero_target) begin
        avg_x_q <= '0;
        avg_y_q <= '0;
      end
    end
    if (cmd_i.capture) begin
      unique case (cmd_i.op)
        jad_pkg::OP_AVG_X: avg_x_q <= quotient[jad_pkg::SAMPLE_W-1:0];
        jad_pkg::OP_AVG_Y: avg_y_q <= quotient[jad_pkg::SAMPLE_W-1:0];
        jad_pkg::OP_PCT_X: pct_x_q <= pct_res;
        jad_pkg::OP_PCT_Y: pct_y_q <= pct_res;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_cal_q   <= (mode_q == jad_pkg::MODE_CALIB);
      out_avg_x_q <= avg_x_q;
      out_avg_y_q <= avg_y_q;
      out_pct_x_q <= (mode_q == jad_pkg::MODE_MEASURE) ? pct_x_q : '0;
      out_pct_y_q <= (mode_q == jad_pkg::MODE_MEASURE) ? pct_y_q : '0;
      out_dir_q   <= (mode_q == jad_pkg::MODE_MEASURE) ? dir : jad_pkg::DIR_NEUTRAL;
    end
  end

  assign sts_o.in_mode     = in_mode_i;
  assign sts_o.zero_target = zero_target;
  assign sts_o.close       = close;
  assign sts_o.mode        = mode_q;
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_cal_o   = out_cal_q;
  assign out_avg_x_o = out_avg_x_q;
  assign out_avg_y_o = out_avg_y_q;
  assign out_pct_x_o = out_pct_x_q;
  assign out_pct_y_o = out_pct_y_q;
  assign out_dir_o   = out_dir_q;

endmodule

`default_nettype wire

FILE: rtl/jad_ctrl.sv
// Controller state machine sequencing accumulation, divisions and result hand-off.
`default_nettype none

module jad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  jad_pkg::sts_t sts_i,
  output jad_pkg::cmd_t cmd_o
);

  jad_pkg::ctrl_state_e state_q, state_d;
  jad_pkg::op_e         op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jad_pkg::ST_IDLE;
      op_q    <= jad_pkg::OP_AVG_X;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    in_ready_o    = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.op      = op_q;
    unique case (state_q)
      jad_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.zero_target) begin
            if (sts_i.in_mode == jad_pkg::MODE_MEASURE) begin
              op_d    = jad_pkg::OP_PCT_X;
              state_d = jad_pkg::ST_LAUNCH;
            end else begin
              state_d = jad_pkg::ST_EMIT;
            end
          end else if (sts_i.close) begin
            op_d    = jad_pkg::OP_AVG_X;
            state_d = jad_pkg::ST_LAUNCH;
          end
        end
      end
      jad_pkg::ST_LAUNCH: begin
        cmd_o.start = 1'b1;
        state_d     = jad_pkg::ST_WAIT;
      end
      jad_pkg::ST_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.capture = 1'b1;
          unique case (op_q)
            jad_pkg::OP_AVG_X: begin
              op_d    = jad_pkg::OP_AVG_Y;
              state_d = jad_pkg::ST_LAUNCH;
            end
            jad_pkg::OP_AVG_Y: begin
              if (sts_i.mode == jad_pkg::MODE_MEASURE) begin
                op_d    = jad_pkg::OP_PCT_X;
                state_d = jad_pkg::ST_LAUNCH;
              end else begin
                state_d = jad_pkg::ST_EMIT;
              end
            end
            jad_pkg::OP_PCT_X: begin
              op_d    = jad_pkg::OP_PCT_Y;
              state_d = jad_pkg::ST_LAUNCH;
            end
            jad_pkg::OP_PCT_Y: begin
              state_d = jad_pkg::ST_EMIT;
            end
          endcase
        end
      end
      jad_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = jad_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/joystick_axis_direction.sv
// Top level: one shared divider runs twice for the averages of a closing sample
// and, for a closing measurement sample, twice more for the percents.
// A zero sample count skips the averages. The output register holds one result.
// Reset (rst_ni low, asynchronous) restores register defaults and clears sums and zeros.
`default_nettype none

module joystick_axis_direction (
  input  logic         clk_i,
  input  logic         rst_ni,
  jad_sample_if.sink   sample_i,
  jad_result_if.source result_o,
  jad_cfg_if.sink      cfg_i
);

  jad_pkg::cmd_t cmd;
  jad_pkg::sts_t sts;
  logic          in_ready;

  assign sample_i.ready = in_ready;
  assign cfg_i.ready    = 1'b1;

  jad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jad_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (sample_i.mode),
    .in_x_i      (sample_i.sample_x),
    .in_y_i      (sample_i.sample_y),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_cal_o   (result_o.was_calibration),
    .out_avg_x_o (result_o.avg_x),
    .out_avg_y_o (result_o.avg_y),
    .out_pct_x_o (result_o.percent_x),
    .out_pct_y_o (result_o.percent_y),
    .out_dir_o   (result_o.direction)
  );

endmodule

`default_nettype wire

FILE: rtl/jad_checker.sv
// Port-level checker for the joystick axis direction block, bound to the top level.
`default_nettype none

module jad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_cal_i,
  input logic [7:0]  out_avg_x_i,
  input logic [15:0] out_pct_x_i,
  input logic [15:0] out_pct_y_i,
  input logic [2:0]  out_dir_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_avg_x_i) && $stable(out_pct_x_i))
    else $error("stalled result changed");

  a_no_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result appeared right after a sample transaction");

  a_cal_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_cal_i |-> out_pct_x_i == '0 && out_pct_y_i == '0 && out_dir_i == '0)
    else $error("calibration result carries deflection");

endmodule

bind joystick_axis_direction jad_checker u_jad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_cal_i   (result_o.was_calibration),
  .out_avg_x_i (result_o.avg_x),
  .out_pct_x_i (result_o.percent_x),
  .out_pct_y_i (result_o.percent_y),
  .out_dir_i   (result_o.direction)
);

`default_nettype wire

FILE: dv/joystick_axis_direction_chk.sv
// Checker that tracks joystick channel traffic, predicts each result and compares it.
`timescale 1ns / 1ps

module joystick_axis_direction_chk
  import jad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               smp_valid_i,
  input  logic               smp_ready_i,
  input  logic               smp_mode_i,
  input  logic [7:0]         smp_x_i,
  input  logic [7:0]         smp_y_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic               res_was_cal_i,
  input  logic [7:0]         res_avg_x_i,
  input  logic [7:0]         res_avg_y_i,
  input  logic signed [15:0] res_pct_x_i,
  input  logic signed [15:0] res_pct_y_i,
  input  logic [2:0]         res_dir_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic               was_cal;
    logic [7:0]         avg_x;
    logic [7:0]         avg_y;
    logic signed [15:0] pct_x;
    logic signed [15:0] pct_y;
    dir_e               dir;
  } joy_result_t;

  joy_result_t expected_q[$];

  logic [7:0]  dz_r;
  logic [7:0]  min_r;
  logic [7:0]  max_r;
  logic [3:0]  meas_n;
  logic [3:0]  cal_n;
  logic [11:0] acc_x;
  logic [11:0] acc_y;
  logic [3:0]  n_acc;
  logic [7:0]  zero_x;
  logic [7:0]  zero_y;
  logic        grp_mode;
  int          miss_count = 0;
  int          awaiting = 0;

  assign fail_count_o = miss_count;
  assign pending_o    = awaiting;

  function automatic int axis_percent(logic [7:0] val, logic [7:0] zero);
    int unsigned num;
    logic [15:0] den;
    if (val >= zero) begin
      num = (int'(val) - int'(zero)) * 100;
      den = {8'h00, max_r} - {8'h00, zero};
      return (den == 16'd0) ? 0 : int'(num / int'(den));
    end
    num = (int'(zero) - int'(val)) * 100;
    den = {8'h00, zero} - {8'h00, min_r};
    return (den == 16'd0) ? 0 : -int'(num / int'(den));
  endfunction

  function automatic dir_e pick_direction(int px, int py);
    int mag_y;
    int dzi;
    mag_y = (py < 0) ? -py : py;
    dzi   = int'(dz_r);
    if (px > dzi && px >= mag_y) return DIR_RIGHT;
    if (px < -dzi && -px >= mag_y) return DIR_LEFT;
    if (py > dzi) return DIR_UP;
    if (py < -dzi) return DIR_DOWN;
    return DIR_NEUTRAL;
  endfunction

  task automatic report_fail(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    miss_count++;
  endtask

  task automatic absorb_sample(logic m, logic [7:0] x, logic [7:0] y);
    logic [3:0]  target;
    logic [7:0]  ax;
    logic [7:0]  ay;
    int          px;
    int          py;
    joy_result_t r;
    target = (m == MODE_MEASURE) ? meas_n : cal_n;
    if (target == 4'd0) begin
      acc_x    = '0;
      acc_y    = '0;
      n_acc    = '0;
      grp_mode = m;
      ax       = '0;
      ay       = '0;
    end else begin
      if (n_acc != 4'd0 && grp_mode != m) begin
        acc_x = '0;
        acc_y = '0;
        n_acc = '0;
      end
      grp_mode = m;
      acc_x    = acc_x + {4'h0, x};
      acc_y    = acc_y + {4'h0, y};
      n_acc    = n_acc + 4'd1;
      if (n_acc < target) return;
      ax    = 8'(acc_x / {8'h00, n_acc});
      ay    = 8'(acc_y / {8'h00, n_acc});
      acc_x = '0;
      acc_y = '0;
      n_acc = '0;
    end
    r       = '0;
    r.avg_x = ax;
    r.avg_y = ay;
    r.dir   = DIR_NEUTRAL;
    if (m == MODE_CALIB) begin
      r.was_cal = 1'b1;
      zero_x    = ax;
      zero_y    = ay;
    end else begin
      px      = axis_percent(ax, zero_x);
      py      = axis_percent(ay, zero_y);
      r.pct_x = 16'(px);
      r.pct_y = 16'(py);
      r.dir   = pick_direction(px, py);
    end
    expected_q.push_back(r);
  endtask

  task automatic compare_result();
    joy_result_t want;
    if (expected_q.size() == 0) begin
      report_fail("result transaction with no expectation waiting");
      return;
    end
    want = expected_q.pop_front();
    if (res_was_cal_i !== want.was_cal)
      report_fail($sformatf("was_calibration got %0d expected %0d", res_was_cal_i, want.was_cal));
    if (res_avg_x_i !== want.avg_x)
      report_fail($sformatf("avg_x got %0d expected %0d", res_avg_x_i, want.avg_x));
    if (res_avg_y_i !== want.avg_y)
      report_fail($sformatf("avg_y got %0d expected %0d", res_avg_y_i, want.avg_y));
    if (res_pct_x_i !== want.pct_x)
      report_fail($sformatf("percent_x got %0d expected %0d", res_pct_x_i, want.pct_x));
    if (res_pct_y_i !== want.pct_y)
      report_fail($sformatf("percent_y got %0d expected %0d", res_pct_y_i, want.pct_y));
    if (res_dir_i !== want.dir)
      report_fail($sformatf("direction got %0d expected %0d", res_dir_i, want.dir));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_r     = DEADZONE_RST;
      min_r    = AXIS_MIN_RST;
      max_r    = AXIS_MAX_RST;
      meas_n   = MEASURE_SAMPLES_RST;
      cal_n    = CALIB_SAMPLES_RST;
      acc_x    = '0;
      acc_y    = '0;
      n_acc    = '0;
      zero_x   = '0;
      zero_y   = '0;
      grp_mode = MODE_CALIB;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DEADZONE:        dz_r   = cfg_data_i;
          CFG_AXIS_MIN:        min_r  = cfg_data_i;
          CFG_AXIS_MAX:        max_r  = cfg_data_i;
          CFG_MEASURE_SAMPLES: meas_n = cfg_data_i[3:0];
          CFG_CALIB_SAMPLES:   cal_n  = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (smp_valid_i && smp_ready_i) absorb_sample(smp_mode_i, smp_x_i, smp_y_i);
      if (res_valid_i && res_ready_i) compare_result();
    end
    awaiting = expected_q.size();
  end

endmodule

FILE: dv/joystick_axis_direction_tb.sv
// Testbench top: clock, reset, sample and register stimulus, result backpressure, verdict.
`timescale 1ns / 1ps

module joystick_axis_direction_tb;
  import jad_pkg::*;

  localparam int LIMIT        = 1_000_000;
  localparam int DRAIN        = 100;
  localparam int PHASES       = 24;
  localparam int RANDOM_ITEMS = 1850;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          idling = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  logic [3:0]  meas_len = MEASURE_SAMPLES_RST;
  logic [3:0]  cal_len = CALIB_SAMPLES_RST;
  int          fail_count;
  int          pending;

  jad_sample_if smp ();
  jad_result_if res ();
  jad_cfg_if    cfg ();

  joystick_axis_direction dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  joystick_axis_direction_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .smp_valid_i   (smp.valid),
    .smp_ready_i   (smp.ready),
    .smp_mode_i    (smp.mode),
    .smp_x_i       (smp.sample_x),
    .smp_y_i       (smp.sample_y),
    .res_valid_i   (res.valid),
    .res_ready_i   (res.ready),
    .res_was_cal_i (res.was_calibration),
    .res_avg_x_i   (res.avg_x),
    .res_avg_y_i   (res.avg_y),
    .res_pct_x_i   (res.percent_x),
    .res_pct_y_i   (res.percent_y),
    .res_dir_i     (res.direction),
    .cfg_valid_i   (cfg.valid),
    .cfg_ready_i   (cfg.ready),
    .cfg_index_i   (cfg.index),
    .cfg_data_i    (cfg.data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  task automatic send_sample(logic m, logic [7:0] x, logic [7:0] y);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      smp.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    smp.valid    <= 1'b1;
    smp.mode     <= m;
    smp.sample_x <= x;
    smp.sample_y <= y;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  // hold off until every expected result is out and the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    smp.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] value);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    if (idx == CFG_MEASURE_SAMPLES) meas_len = value[3:0];
    if (idx == CFG_CALIB_SAMPLES) cal_len = value[3:0];
  endtask

  function automatic logic [7:0] rand_sample(logic [7:0] centre);
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'($urandom);
      default: return 8'(int'(centre) + int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic logic [7:0] pick_reg(int lo, int hi);
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [7:0] pick_count();
    logic [3:0] n;
    case ($urandom_range(0, 9))
      0:       n = 4'd0;
      1:       n = 4'd15;
      default: n = 4'($urandom_range(1, 4));
    endcase
    return {4'($urandom), n};
  endfunction

  initial begin
    int         sent;
    int         budget;
    int         len;
    logic       m;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] tx;
    logic [7:0] ty;

    smp.valid    = 1'b0;
    smp.mode     = MODE_CALIB;
    smp.sample_x = '0;
    smp.sample_y = '0;
    cfg.valid    = 1'b0;
    cfg.index    = CFG_DEADZONE;
    cfg.data     = '0;
    res.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    repeat (4) send_sample(MODE_CALIB, 8'd128, 8'd128);
    repeat (2) send_sample(MODE_MEASURE, 8'd255, 8'd128);
    repeat (2) send_sample(MODE_MEASURE, 8'd0, 8'd128);
    repeat (2) send_sample(MODE_MEASURE, 8'd128, 8'd255);
    repeat (2) send_sample(MODE_MEASURE, 8'd128, 8'd0);
    repeat (2) send_sample(MODE_MEASURE, 8'd255, 8'd255);
    send_sample(MODE_CALIB, 8'd10, 8'd10);
    repeat (2) send_sample(MODE_MEASURE, 8'd140, 8'd100);

    settle();
    write_reg(CFG_MEASURE_SAMPLES, 8'd0);
    send_sample(MODE_MEASURE, 8'd77, 8'd77);
    settle();
    write_reg(CFG_CALIB_SAMPLES, 8'd0);
    send_sample(MODE_CALIB, 8'd5, 8'd5);

    settle();
    write_reg(CFG_CALIB_SAMPLES, 8'd1);
    write_reg(CFG_MEASURE_SAMPLES, 8'd1);
    write_reg(CFG_AXIS_MAX, 8'd200);
    write_reg(CFG_AXIS_MIN, 8'd60);
    send_sample(MODE_CALIB, 8'd200, 8'd60);
    send_sample(MODE_MEASURE, 8'd255, 8'd30);

    settle();
    write_reg(CFG_CALIB_SAMPLES, 8'd4);
    repeat (3) send_sample(MODE_CALIB, 8'($urandom), 8'($urandom));
    settle();
    write_reg(CFG_CALIB_SAMPLES, 8'd2);
    send_sample(MODE_CALIB, 8'd250, 8'd3);

    budget = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      idling = (p < PHASES - 3) && (p % 4 != 1);
      write_reg(CFG_DEADZONE, pick_reg(5, 60));
      write_reg(CFG_AXIS_MIN, pick_reg(60, 130));
      write_reg(CFG_AXIS_MAX, pick_reg(150, 255));
      write_reg(CFG_MEASURE_SAMPLES, pick_count());
      write_reg(CFG_CALIB_SAMPLES, pick_count());
      cx   = 8'($urandom_range(90, 170));
      cy   = 8'($urandom_range(90, 170));
      sent = 0;
      while (sent < budget) begin
        if ($urandom_range(0, 9) < 8) begin
          m   = ($urandom_range(0, 3) == 0) ? MODE_CALIB : MODE_MEASURE;
          len = (m == MODE_MEASURE) ? int'(meas_len) : int'(cal_len);
          if (len == 0) len = 1;
          tx = (m == MODE_MEASURE) ? rand_sample(cx) : cx;
          ty = (m == MODE_MEASURE) ? rand_sample(cy) : cy;
          repeat (len) begin
            if ($urandom_range(0, 7) == 0)
              send_sample(m, 8'($urandom), 8'($urandom));
            else
              send_sample(m, 8'(int'(tx) + int'($urandom_range(0, 6)) - 3),
                          8'(int'(ty) + int'($urandom_range(0, 6)) - 3));
          end
          sent += len;
        end else begin
          len = $urandom_range(1, 3);
          repeat (len) send_sample(1'($urandom), rand_sample(cx), rand_sample(cy));
          sent += len;
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
